// File: src/fan_speed_timer_controller_macros.svh
// ----------------------------------------------------------------------------
// Fan speed timer controller assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_TIMER_CONTROLLER_MACROS_SVH
`define FAN_SPEED_TIMER_CONTROLLER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define FSTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fstc check failed");

// Next-cycle implication, masked while reset is asserted.
`define FSTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fstc check failed");

// Next-cycle implication that also holds across reset.
`define FSTC_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("fstc check failed");

`endif

// File: src/fstc_pkg.sv
// ----------------------------------------------------------------------------
// fstc_pkg
// Types and constants of the fan speed timer controller.
// ----------------------------------------------------------------------------
package fstc_pkg;

    // IR command bytes
    localparam logic [7:0] IR_ON_CODE   = 8'h30;
    localparam logic [7:0] IR_OFF_CODE  = 8'h90;
    localparam logic [7:0] IR_TIME_CODE = 8'hA0;

    // Countdown load per selected hour
    localparam logic [13:0] SECS_1H = 14'd3600;
    localparam logic [13:0] SECS_2H = 14'd7200;
    localparam logic [13:0] SECS_4H = 14'd14400;

    // Buzzer sequencer phases
    localparam logic [1:0] BEEP_IDLE = 2'd0;
    localparam logic [1:0] BEEP_ON   = 2'd1;
    localparam logic [1:0] BEEP_GAP  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_SHORT_BEEP = 3'd0;
    localparam logic [2:0] CFG_LONG_BEEP  = 3'd1;
    localparam logic [2:0] CFG_BEEP_GAP   = 3'd2;
    localparam logic [2:0] CFG_DEB_PERIOD = 3'd3;
    localparam logic [2:0] CFG_DEB_THRESH = 3'd4;
    localparam logic [2:0] CFG_TICKS_SEC  = 3'd5;

    typedef struct packed {
        logic [15:0] short_beep_ms;
        logic [15:0] long_beep_ms;
        logic [15:0] beep_gap_ms;
        logic [7:0]  debounce_period_ms;
        logic [3:0]  debounce_threshold;
        logic [15:0] ticks_per_second;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        short_beep_ms:      16'd80,
        long_beep_ms:       16'd400,
        beep_gap_ms:        16'd120,
        debounce_period_ms: 8'd10,
        debounce_threshold: 4'd3,
        ticks_per_second:   16'd1000
    };

    typedef struct packed {
        logic       on_key_raw;
        logic       off_key_raw;
        logic       ir_valid;
        logic [7:0] ir_code;
    } t_tick;

    typedef struct packed {
        logic [1:0]  fan_speed;
        logic [2:0]  timer_hours;
        logic        buzzer_on;
        logic [13:0] seconds_left;
    } t_status;

endpackage

// File: src/fstc_in_if.sv
// ----------------------------------------------------------------------------
// fstc_in_if
// Tick channel: one word per millisecond with key levels and IR command.
// ----------------------------------------------------------------------------
interface fstc_in_if;
    logic       valid;
    logic       ready;
    logic       on_key_raw;
    logic       off_key_raw;
    logic       ir_valid;
    logic [7:0] ir_code;

    modport source (output valid, output on_key_raw, output off_key_raw,
                    output ir_valid, output ir_code, input ready);
    modport sink   (input valid, input on_key_raw, input off_key_raw,
                    input ir_valid, input ir_code, output ready);
endinterface

// File: src/fstc_out_if.sv
// ----------------------------------------------------------------------------
// fstc_out_if
// Status channel: fan speed, timer and buzzer state after each tick.
// ----------------------------------------------------------------------------
interface fstc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fan_speed;
    logic [2:0]  timer_hours;
    logic        buzzer_on;
    logic [13:0] seconds_left;

    modport source (output valid, output fan_speed, output timer_hours,
                    output buzzer_on, output seconds_left, input ready);
    modport sink   (input valid, input fan_speed, input timer_hours,
                    input buzzer_on, input seconds_left, output ready);
endinterface

// File: src/fstc_debounce.sv
// ----------------------------------------------------------------------------
// fstc_debounce
// Saturating integrator key debouncer with rising-edge fire pulse.
// ----------------------------------------------------------------------------
module fstc_debounce (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_raw,
    input  logic [3:0] i_threshold,
    output logic       o_fire
);

    logic [3:0] r_integ;
    logic [3:0] n_integ;
    logic       r_held;
    logic       n_held;

    always_comb begin
        n_integ = r_integ;
        if (i_raw) begin
            if (r_integ < i_threshold) begin
                n_integ = r_integ + 4'd1;
            end
        end else if (r_integ != 4'd0) begin
            n_integ = r_integ - 4'd1;
        end
        n_held = (n_integ >= i_threshold);
    end

    assign o_fire = i_en && n_held && !r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_held  <= 1'b0;
        end else if (i_en) begin
            r_integ <= n_integ;
            r_held  <= n_held;
        end
    end

endmodule

// File: src/fstc_ctrl.sv
// ----------------------------------------------------------------------------
// fstc_ctrl
// Per-tick state update: buzzer, debounce, countdown and IR, in that order.
// ----------------------------------------------------------------------------
module fstc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  fstc_pkg::t_tick  i_tick,
    input  fstc_pkg::t_cfg   i_cfg,
    output fstc_pkg::t_status o_status
);

    typedef struct packed {
        logic [1:0]  phase;
        logic [2:0]  left;
        logic [31:0] deadline;
        logic [15:0] on_len;
        logic [15:0] off_len;
        logic [2:0]  followup;
    } t_beep;

    function automatic t_beep f_start(input t_beep b, input logic [2:0] count,
                                      input logic [15:0] on_len,
                                      input logic [15:0] gap,
                                      input logic [31:0] now);
        t_beep r;
        r = b;
        if (count != 3'd0) begin
            r.followup = '0;
            r.left     = count;
            r.on_len   = on_len;
            r.off_len  = gap;
            r.phase    = fstc_pkg::BEEP_ON;
            r.deadline = now + {16'd0, on_len};
        end
        return r;
    endfunction

    logic [31:0] r_ms,       n_ms;
    logic [31:0] r_deb_mark, n_deb_mark;
    logic [31:0] r_sec_mark, n_sec_mark;
    logic [1:0]  r_speed,    n_speed;
    logic [2:0]  r_hours,    n_hours;
    logic [13:0] r_cnt,      n_cnt;
    t_beep       r_beep,     n_beep;

    logic [31:0] w_due_diff;
    logic [31:0] w_deb_diff;
    logic [31:0] w_sec_diff;
    logic        w_deb_hit;
    logic        w_sec_hit;
    logic        w_deb_en;
    logic        w_on_fire;
    logic        w_off_fire;
    logic [2:0]  w_shorts;

    assign n_ms       = r_ms + 32'd1;
    assign w_due_diff = n_ms - r_beep.deadline;
    assign w_deb_diff = n_ms - r_deb_mark;
    assign w_sec_diff = n_ms - r_sec_mark;
    assign w_deb_hit  = (w_deb_diff >= {24'd0, i_cfg.debounce_period_ms});
    assign w_sec_hit  = (w_sec_diff >= {16'd0, i_cfg.ticks_per_second});
    assign w_deb_en   = i_adv && w_deb_hit;

    fstc_debounce u_on_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_deb_en),
        .i_raw       (i_tick.on_key_raw),
        .i_threshold (i_cfg.debounce_threshold),
        .o_fire      (w_on_fire)
    );

    fstc_debounce u_off_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_deb_en),
        .i_raw       (i_tick.off_key_raw),
        .i_threshold (i_cfg.debounce_threshold),
        .o_fire      (w_off_fire)
    );

    always_comb begin
        n_beep     = r_beep;
        n_speed    = r_speed;
        n_hours    = r_hours;
        n_cnt      = r_cnt;
        n_deb_mark = r_deb_mark;
        n_sec_mark = r_sec_mark;
        w_shorts   = '0;

        // buzzer: deadline reached when (now - deadline) is not negative
        if (r_beep.phase != fstc_pkg::BEEP_IDLE && !w_due_diff[31]) begin
            if (r_beep.phase == fstc_pkg::BEEP_ON) begin
                n_beep.phase    = fstc_pkg::BEEP_GAP;
                n_beep.deadline = n_ms + {16'd0, r_beep.off_len};
            end else if (r_beep.left > 3'd1) begin
                n_beep.left     = r_beep.left - 3'd1;
                n_beep.phase    = fstc_pkg::BEEP_ON;
                n_beep.deadline = n_ms + {16'd0, r_beep.on_len};
            end else begin
                w_shorts        = r_beep.followup;
                n_beep.phase    = fstc_pkg::BEEP_IDLE;
                n_beep.left     = '0;
                n_beep.followup = '0;
                n_beep = f_start(n_beep, w_shorts, i_cfg.short_beep_ms,
                                 i_cfg.beep_gap_ms, n_ms);
            end
        end

        // keys
        if (w_deb_hit) begin
            n_deb_mark = r_deb_mark + {24'd0, i_cfg.debounce_period_ms};
        end
        if (w_on_fire) begin
            n_beep  = f_start(n_beep, 3'd1, i_cfg.short_beep_ms, i_cfg.beep_gap_ms, n_ms);
            n_speed = (n_speed == 2'd3) ? 2'd1 : n_speed + 2'd1;
        end
        if (w_off_fire) begin
            n_beep  = f_start(n_beep, 3'd1, i_cfg.short_beep_ms, i_cfg.beep_gap_ms, n_ms);
            n_speed = '0;
            n_hours = '0;
            n_cnt   = '0;
        end

        // off-timer countdown, only while the fan turns
        if (w_sec_hit) begin
            n_sec_mark = r_sec_mark + {16'd0, i_cfg.ticks_per_second};
            if (n_cnt != 14'd0 && n_speed != 2'd0) begin
                n_cnt = n_cnt - 14'd1;
                if (n_cnt == 14'd0) begin
                    n_hours = '0;
                    n_speed = '0;
                    n_beep  = f_start(n_beep, 3'd1, i_cfg.long_beep_ms,
                                      i_cfg.beep_gap_ms, n_ms);
                end
            end
        end

        // IR command
        if (i_tick.ir_valid) begin
            if (i_tick.ir_code == fstc_pkg::IR_ON_CODE) begin
                n_beep  = f_start(n_beep, 3'd1, i_cfg.short_beep_ms,
                                  i_cfg.beep_gap_ms, n_ms);
                n_speed = (n_speed == 2'd3) ? 2'd1 : n_speed + 2'd1;
            end else if (i_tick.ir_code == fstc_pkg::IR_OFF_CODE) begin
                n_beep  = f_start(n_beep, 3'd1, i_cfg.short_beep_ms,
                                  i_cfg.beep_gap_ms, n_ms);
                n_speed = '0;
                n_hours = '0;
                n_cnt   = '0;
            end else if (i_tick.ir_code == fstc_pkg::IR_TIME_CODE) begin
                // hours rotate 0 -> 1 -> 2 -> 4 -> 0
                unique case (n_hours)
                    3'd0:    begin n_hours = 3'd1; n_cnt = fstc_pkg::SECS_1H; end
                    3'd1:    begin n_hours = 3'd2; n_cnt = fstc_pkg::SECS_2H; end
                    3'd2:    begin n_hours = 3'd4; n_cnt = fstc_pkg::SECS_4H; end
                    default: begin n_hours = 3'd0; n_cnt = '0; end
                endcase
                if (n_hours != 3'd0) begin
                    n_beep = f_start(n_beep, 3'd1, i_cfg.long_beep_ms,
                                     i_cfg.beep_gap_ms, n_ms);
                    n_beep.followup = n_hours;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms       <= '0;
            r_deb_mark <= '0;
            r_sec_mark <= '0;
            r_speed    <= '0;
            r_hours    <= '0;
            r_cnt      <= '0;
            r_beep     <= '0;
        end else if (i_adv) begin
            r_ms       <= n_ms;
            r_deb_mark <= n_deb_mark;
            r_sec_mark <= n_sec_mark;
            r_speed    <= n_speed;
            r_hours    <= n_hours;
            r_cnt      <= n_cnt;
            r_beep     <= n_beep;
        end
    end

    assign o_status.fan_speed    = n_speed;
    assign o_status.timer_hours  = n_hours;
    assign o_status.buzzer_on    = (n_beep.phase == fstc_pkg::BEEP_ON);
    assign o_status.seconds_left = n_cnt;

endmodule

// File: src/fan_speed_timer_controller.sv
// ----------------------------------------------------------------------------
// fan_speed_timer_controller
// Fan speed, off-timer and buzzer controller advanced by millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick carries one word per millisecond tick: ON/OFF key levels and an
//   optional IR command. o_status returns one word per tick: fan speed,
//   selected timer hours, buzzer level and remaining timer seconds.
//   A word accepted from i_tick is captured in the input register, processed
//   by the update logic into the output register when it can advance, and
//   shown on o_status from the output register.
//   Throughput: one tick per cycle while the receiver takes each word; the
//   whole update (buzzer, debouncers, countdown, IR) is a single pass of
//   logic between the input register and the output register.
//   If the receiver stalls, the output register holds its word and the
//   input register takes ticks only until it is full, then i_tick.ready drops.
//   Reset (synchronous, active low) clears the controller state, empties both
//   registers and loads the default beep, debounce and second settings.
//   The user must write settings through i_cfg_we/i_cfg_idx/i_cfg_data only
//   while idle; the block does not enforce it. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module fan_speed_timer_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    fstc_in_if.sink     i_tick,
    fstc_out_if.source  o_status
);

    fstc_pkg::t_cfg    r_cfg;
    fstc_pkg::t_tick   r_in;
    logic              r_in_vld;
    fstc_pkg::t_status r_out;
    logic              r_out_vld;
    fstc_pkg::t_status w_next;
    logic              w_adv;

    assign w_adv        = r_in_vld && (!r_out_vld || o_status.ready);
    assign i_tick.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fstc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fstc_pkg::CFG_SHORT_BEEP: r_cfg.short_beep_ms      <= i_cfg_data;
                fstc_pkg::CFG_LONG_BEEP:  r_cfg.long_beep_ms       <= i_cfg_data;
                fstc_pkg::CFG_BEEP_GAP:   r_cfg.beep_gap_ms        <= i_cfg_data;
                fstc_pkg::CFG_DEB_PERIOD: r_cfg.debounce_period_ms <= i_cfg_data[7:0];
                fstc_pkg::CFG_DEB_THRESH: r_cfg.debounce_threshold <= i_cfg_data[3:0];
                fstc_pkg::CFG_TICKS_SEC:  r_cfg.ticks_per_second   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_vld <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in.on_key_raw  <= i_tick.on_key_raw;
            r_in.off_key_raw <= i_tick.off_key_raw;
            r_in.ir_valid    <= i_tick.ir_valid;
            r_in.ir_code     <= i_tick.ir_code;
        end
    end

    fstc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_tick   (r_in),
        .i_cfg    (r_cfg),
        .o_status (w_next)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_status.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_next;
        end
    end

    assign o_status.valid        = r_out_vld;
    assign o_status.fan_speed    = r_out.fan_speed;
    assign o_status.timer_hours  = r_out.timer_hours;
    assign o_status.buzzer_on    = r_out.buzzer_on;
    assign o_status.seconds_left = r_out.seconds_left;

endmodule

// File: src/fstc_chk.sv
// ----------------------------------------------------------------------------
// fstc_chk
// Port-level checks on the status channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "fan_speed_timer_controller_macros.svh"

module fstc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_fan_speed,
    input logic [2:0]  i_timer_hours,
    input logic        i_buzzer_on,
    input logic [13:0] i_seconds_left
);

    logic [19:0] w_word;
    logic        w_hours_ok;
    logic        w_cnt_ok;

    assign w_word     = {i_fan_speed, i_timer_hours, i_buzzer_on, i_seconds_left};
    assign w_hours_ok = (i_timer_hours == 3'd0) || (i_timer_hours == 3'd1) ||
                        (i_timer_hours == 3'd2) || (i_timer_hours == 3'd4);
    assign w_cnt_ok   = (i_timer_hours != 3'd0) && (i_seconds_left <= 14'd14400);

    // nothing comes out of reset with a word pending
    `FSTC_ASSERT_RST(a_rst_empty, !i_rst_n, !i_out_valid)

    // a stalled word holds
    `FSTC_ASSERT_NXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(w_word))

    // hours only take the rotation values
    `FSTC_ASSERT_IMP(a_hours_legal, i_out_valid, w_hours_ok)

    // a running countdown always has hours selected and stays in range
    `FSTC_ASSERT_IMP(a_cnt_hours, i_out_valid && i_seconds_left != 14'd0, w_cnt_ok)

endmodule

bind fan_speed_timer_controller fstc_chk u_fstc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_status.valid),
    .i_out_ready    (o_status.ready),
    .i_fan_speed    (o_status.fan_speed),
    .i_timer_hours  (o_status.timer_hours),
    .i_buzzer_on    (o_status.buzzer_on),
    .i_seconds_left (o_status.seconds_left)
);
